// ----- rtl/svfc_pkg.sv -----
// Shared types and constants for the sorted value frequency counter.
// No dependencies; imported by svfc_cell and sorted_value_frequency_count.
package svfc_pkg;

   localparam int ITEMS       = 16;  // items in a set when last never comes (2..64)
   localparam int TABLE_DEPTH = 16;
   localparam int VALUE_W     = 10;
   localparam int COUNT_W     = 5;
   localparam int ITEMS_W     = (ITEMS > 1) ? $clog2(ITEMS) : 1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               last;
   } svfc_req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] distinct_value;
      logic [COUNT_W-1:0] occurrences;
      logic               final_res;
   } svfc_rsp_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic               insert;
      logic               hit;
      logic               full;
      logic               drain;
   } svfc_ctrl_type;

   // what a cell shows to its neighbors and to the top level
   typedef struct packed {
      logic               valid;
      logic               lt;
      logic               eq;
      logic [VALUE_W-1:0] value;
      logic [COUNT_W-1:0] count;
   } svfc_link_type;

endpackage

// ----- rtl/svfc_cell.sv -----
// One table entry of the sorted chain: value, count and valid bit.
// Depends on svfc_pkg.
module svfc_cell
   import svfc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  svfc_ctrl_type      ctrl,
   input  logic [VALUE_W-1:0] key,
   input  svfc_link_type      left,
   input  svfc_link_type      right,
   output svfc_link_type      self
);

   logic               valid_ff, valid_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               lt, eq;

   // compare against the incoming value, kept apart from ctrl
   assign lt = valid_ff && (value_ff < key);
   assign eq = valid_ff && (value_ff == key);

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      count_in = count_ff;
      if (ctrl.drain) begin
         valid_in = right.valid;
         value_in = right.value;
         count_in = right.count;
      end else if (ctrl.insert) begin
         if (ctrl.hit) begin
            if (eq && count_ff != COUNT_MAX) begin
               count_in = count_ff + 1'b1;
            end
         end else if (!ctrl.full && !lt) begin
            // left below the new value: this is the slot; else make room
            if (left.lt) begin
               valid_in = 1'b1;
               value_in = key;
               count_in = COUNT_W'(1);
            end else if (left.valid) begin
               valid_in = 1'b1;
               value_in = left.value;
               count_in = left.count;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      count_ff <= count_in;
   end

   assign self = '{valid: valid_ff, lt: lt, eq: eq, value: value_ff, count: count_ff};

endmodule

// ----- rtl/sorted_value_frequency_count.sv -----
// Sorted value frequency counter: top level with the cell chain and drain control.
// Depends on svfc_pkg and svfc_cell.
//
// Items arrive on req_ (value, last). Each accepted item is compared against all
// table cells at once and inserted, or counted, in the cycle it is accepted, so
// a set streams in at one item per cycle. A set ends on an item with last set or
// on the ITEMS-th item. The chain then drains out of cell 0 through the rsp_
// output register, lowest value first, one result per cycle while rsp_ready is
// high; rsp_valid rises once the ending item has set state_ff to DRAIN and the
// first result is in the output register; final_res marks the last one. A set
// of N distinct values leaves as N results via the single shift out of cell 0.
// req_ready is low during the drain and returns the cycle after the final
// result is loaded. A stalled receiver holds the output register and freezes
// the drain. New distinct values arriving with all cells in use are dropped;
// counts saturate. Reset clears all cell valid bits, item counter and rsp_valid.
module sorted_value_frequency_count
   import svfc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  svfc_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output svfc_rsp_type rsp_data
);

   typedef enum logic {COLLECT, DRAIN} state_type;

   state_type          state_ff;
   logic [ITEMS_W-1:0] items_ff;
   logic               rsp_valid_ff;
   svfc_rsp_type       rsp_data_ff;

   svfc_ctrl_type         ctrl;
   svfc_link_type         link  [TABLE_DEPTH];
   svfc_link_type         left  [TABLE_DEPTH];
   svfc_link_type         right [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] cell_valid;
   logic [TABLE_DEPTH-1:0] cell_eq;
   logic                   accept;
   logic                   end_set;
   logic                   drain;

   assign req_ready = (state_ff == COLLECT);
   assign accept    = req_valid && req_ready;
   assign end_set   = req_data.last || (items_ff == ITEMS_W'(ITEMS - 1));
   assign drain     = (state_ff == DRAIN) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         cell_valid[i] = link[i].valid;
         cell_eq[i]    = link[i].eq;
      end
   end

   assign ctrl = '{insert: accept, hit: |cell_eq, full: cell_valid[TABLE_DEPTH-1],
                   drain: drain};

   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         // cell 0 sees a "below" left edge so it takes the smallest value
         if (i == 0) begin
            left[i] = '{valid: 1'b0, lt: 1'b1, eq: 1'b0, value: '0, count: '0};
         end else begin
            left[i] = link[i-1];
         end
         if (i == TABLE_DEPTH-1) begin
            right[i] = '0;
         end else begin
            right[i] = link[i+1];
         end
      end
   end

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : gen_cell
      svfc_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctrl  (ctrl),
         .key   (req_data.value),
         .left  (left[g]),
         .right (right[g]),
         .self  (link[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= COLLECT;
         items_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (drain) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            COLLECT: begin
               if (accept) begin
                  if (end_set) begin
                     items_ff <= '0;
                     state_ff <= DRAIN;
                  end else begin
                     items_ff <= items_ff + 1'b1;
                  end
               end
            end
            DRAIN: begin
               if (drain) begin
                  rsp_data_ff  <= '{distinct_value: link[0].value,
                                    occurrences:    link[0].count,
                                    final_res:      !link[1].valid};
                  if (!link[1].valid) begin
                     state_ff <= COLLECT;
                  end
               end
            end
            default: state_ff <= COLLECT;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // occupied cells form a prefix of the chain
   a_prefix: assert property (@(posedge clock) disable iff (reset)
      ((cell_valid >> 1) & ~cell_valid) == '0)
      else $error("svfc: hole in cell chain");

   // while collecting, never more entries than items taken
   a_fill: assert property (@(posedge clock) disable iff (reset)
      state_ff == COLLECT |-> $countones(cell_valid) <= int'(items_ff))
      else $error("svfc: entries exceed items taken");

   // drain entered only with a nonempty table
   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == DRAIN) |-> cell_valid[0])
      else $error("svfc: drain with empty table");

   for (genvar g = 1; g < TABLE_DEPTH; g++) begin : gen_order_chk
      a_order: assert property (@(posedge clock) disable iff (reset)
         link[g].valid |-> link[g-1].value < link[g].value)
         else $error("svfc: table out of order");
   end

endmodule
